// ===== hdl/cone_beam_voxel_backprojector_assert.svh =====
// Assertion macros shared by the backprojector checker.
`ifndef CONE_BEAM_VOXEL_BACKPROJECTOR_ASSERT_SVH
`define CONE_BEAM_VOXEL_BACKPROJECTOR_ASSERT_SVH

// Clocked assertion that is switched off while reset is held.
`define CBVB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define CBVB_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/cbvb_pkg.sv =====
// Types and constants of the cone-beam voxel backprojector.
package cbvb_pkg;

  // Field widths of the channels.
  localparam int DET_IDX_W = 11;
  localparam int WORD_W    = 32;
  localparam int TRIG_W    = 18;
  localparam int CFG_IDX_W = 3;

  // Item commands.
  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_VOXEL = 1'b1
  } cmd_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SRC_DET_DIST  = 3'd0,
    CFG_SRC_OBJ_DIST  = 3'd1,
    CFG_U_PITCH_RECIP = 3'd2,
    CFG_V_PITCH_RECIP = 3'd3,
    CFG_U_FIRST_POS   = 3'd4,
    CFG_V_FIRST_POS   = 3'd5,
    CFG_COLS_USED     = 3'd6,
    CFG_ROWS_USED     = 3'd7
  } cfg_idx_t;

  // Register reset values.
  localparam logic [30:0] RST_SRC_DET_DIST  = 31'd43151974;
  localparam logic [30:0] RST_SRC_OBJ_DIST  = 31'd26850099;
  localparam logic [30:0] RST_U_PITCH_RECIP = 31'd668734;
  localparam logic [30:0] RST_V_PITCH_RECIP = 31'd668734;
  localparam logic signed [31:0] RST_U_FIRST_POS = -32'sd7542145;
  localparam logic signed [31:0] RST_V_FIRST_POS = -32'sd10117775;
  localparam logic [11:0] RST_COLS_USED = 12'd1500;
  localparam logic [11:0] RST_ROWS_USED = 12'd1628;

  // Divider geometry: numerator, divisor and quotient widths.
  localparam int DIV_NW = 82;
  localparam int DIV_DW = 52;
  localparam int DIV_QW = 49;

  // Payload that travels unchanged along the whole pipeline.
  typedef struct packed {
    cmd_t                     cmd;
    logic [DET_IDX_W-1:0]     col;
    logic [DET_IDX_W-1:0]     row;
    logic signed [WORD_W-1:0] sample;
    logic signed [WORD_W-1:0] acc;
  } item_t;

  // Sideband carried alongside the dividers.
  typedef struct packed {
    item_t item;
    logic  rx_neg;
    logic  z_neg;
    logic  den_pos;
  } div_side_t;

endpackage

// ===== hdl/cbvb_in_if.sv =====
// Input channel of the backprojector.
interface cbvb_in_if;
  import cbvb_pkg::*;
  logic                     valid;
  logic                     ready;
  cmd_t                     cmd;
  logic [DET_IDX_W-1:0]     det_col;
  logic [DET_IDX_W-1:0]     det_row;
  logic signed [WORD_W-1:0] sample;
  logic signed [WORD_W-1:0] voxel_x;
  logic signed [WORD_W-1:0] voxel_y;
  logic signed [WORD_W-1:0] voxel_z;
  logic signed [TRIG_W-1:0] cos_view;
  logic signed [TRIG_W-1:0] sin_view;
  logic signed [WORD_W-1:0] acc_in;

  modport source (output valid, cmd, det_col, det_row, sample, voxel_x, voxel_y, voxel_z,
                  cos_view, sin_view, acc_in, input ready);
  modport sink (input valid, cmd, det_col, det_row, sample, voxel_x, voxel_y, voxel_z,
                cos_view, sin_view, acc_in, output ready);
endinterface

// ===== hdl/cbvb_out_if.sv =====
// Result channel of the backprojector.
interface cbvb_out_if;
  import cbvb_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [WORD_W-1:0] acc_out;
  logic                     hit;

  modport source (output valid, acc_out, hit, input ready);
  modport sink (input valid, acc_out, hit, output ready);
endinterface

// ===== hdl/cbvb_cfg_if.sv =====
// Configuration write channel of the backprojector.
interface cbvb_cfg_if;
  import cbvb_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [WORD_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== hdl/cone_beam_voxel_backprojector.sv =====
// Top level of the cone-beam voxel backprojector.
//
// Channels: in_ch carries load items (cmd 0: one detector sample written to
// the projection store) and voxel items (cmd 1: position, view cosine and
// sine, running sum). out_ch returns one result per voxel item: the new
// saturated sum and a flag that the point fell on the detector. Load items
// give no result. cfg_ch writes the geometry registers and is always ready.
// Throughput: one item per cycle while no result is held at the output. The
// three 50-stage quotient pipelines (an entry stage and one stage per
// quotient bit) divide by the distance from the source and run side by side.
// Loads write the store at the same pipeline stage where voxels read it, so
// every voxel sees all loads accepted before it.
// The whole pipeline advances together; when the receiver holds a result,
// in_ch.ready drops and every stage keeps its contents.
// Reset clears the valid bits and restores the register defaults; the
// projection store keeps no reset value and must be loaded before use.
module cone_beam_voxel_backprojector #(
  parameter int MAX_COLS = 2048,
  parameter int MAX_ROWS = 2048
) (
  input  logic       clk,
  input  logic       rst_n,
  cbvb_in_if.sink    in_ch,
  cbvb_out_if.source out_ch,
  cbvb_cfg_if.sink   cfg_ch
);
  import cbvb_pkg::*;

  localparam int MEM_DEPTH = MAX_COLS * MAX_ROWS;
  localparam int MEM_AW    = $clog2(MEM_DEPTH);
  localparam int IXU_W     = $clog2(MAX_COLS);
  localparam int IXV_W     = $clog2(MAX_ROWS);
  localparam int NCU_W     = $clog2(MAX_COLS + 1);
  localparam int NCV_W     = $clog2(MAX_ROWS + 1);
  localparam int DIV_LAT   = DIV_QW + 1;

  localparam logic [DIV_QW-1:0] U_CAP   = DIV_QW'(1) << 47;
  localparam logic [80:0]       POS_CAP = 81'(1) << 62;
  localparam logic [64:0]       TERM_CAP = 65'(1) << 40;
  localparam logic signed [42:0] ACC_MAX = 43'sd2147483647;
  localparam logic signed [42:0] ACC_MIN = -43'sd2147483648;

  // Configuration registers.
  logic [30:0]        dsd_r, dso_r, urecip_r, vrecip_r;
  logic signed [31:0] ufirst_r, vfirst_r;
  logic [11:0]        cols_r, rows_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dsd_r    <= RST_SRC_DET_DIST;
      dso_r    <= RST_SRC_OBJ_DIST;
      urecip_r <= RST_U_PITCH_RECIP;
      vrecip_r <= RST_V_PITCH_RECIP;
      ufirst_r <= RST_U_FIRST_POS;
      vfirst_r <= RST_V_FIRST_POS;
      cols_r   <= RST_COLS_USED;
      rows_r   <= RST_ROWS_USED;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_idx_t'(cfg_ch.index))
        CFG_SRC_DET_DIST:  dsd_r    <= cfg_ch.data[30:0];
        CFG_SRC_OBJ_DIST:  dso_r    <= cfg_ch.data[30:0];
        CFG_U_PITCH_RECIP: urecip_r <= cfg_ch.data[30:0];
        CFG_V_PITCH_RECIP: vrecip_r <= cfg_ch.data[30:0];
        CFG_U_FIRST_POS:   ufirst_r <= $signed(cfg_ch.data);
        CFG_V_FIRST_POS:   vfirst_r <= $signed(cfg_ch.data);
        CFG_COLS_USED:     cols_r   <= cfg_ch.data[11:0];
        CFG_ROWS_USED:     rows_r   <= cfg_ch.data[11:0];
        default: ;
      endcase
    end
  end

  assign cfg_ch.ready = 1'b1;

  // Global advance: every stage moves unless a result is held at the output.
  logic en;
  logic out_valid_r;
  assign en          = !out_valid_r || out_ch.ready;
  assign in_ch.ready = en;

  // Valid bits of the stages outside the dividers.
  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, v7_r, v8_r, v9_r;
  logic vd_r [DIV_LAT];

  // Stage 1: rotation products.
  item_t              it1_r;
  logic signed [49:0] xc_r, ys_r, yc_r, xs_r;
  logic [31:0]        zmag1_r;
  logic               zneg1_r;

  item_t in_item;
  always_comb begin
    in_item.cmd    = in_ch.cmd;
    in_item.col    = in_ch.det_col;
    in_item.row    = in_ch.det_row;
    in_item.sample = in_ch.sample;
    in_item.acc    = in_ch.acc_in;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      it1_r   <= in_item;
      xc_r    <= 50'(in_ch.voxel_x) * 50'(in_ch.cos_view);
      ys_r    <= 50'(in_ch.voxel_y) * 50'(in_ch.sin_view);
      yc_r    <= 50'(in_ch.voxel_y) * 50'(in_ch.cos_view);
      xs_r    <= 50'(in_ch.voxel_x) * 50'(in_ch.sin_view);
      zmag1_r <= in_ch.voxel_z[31] ? 32'(-in_ch.voxel_z) : 32'(in_ch.voxel_z);
      zneg1_r <= in_ch.voxel_z[31];
    end
  end

  // Stage 2: rotated coordinates and distance from the source.
  item_t              it2_r;
  logic [50:0]        rxmag2_r;
  logic               rxneg2_r;
  logic signed [51:0] den2_r;
  logic [31:0]        zmag2_r;
  logic               zneg2_r;
  logic signed [50:0] rx;

  assign rx = 51'(xc_r) + 51'(ys_r);

  always_ff @(posedge clk) begin
    if (en) begin
      it2_r    <= it1_r;
      rxmag2_r <= rx[50] ? 51'(-rx) : 51'(rx);
      rxneg2_r <= rx[50];
      den2_r   <= $signed(52'(yc_r) - 52'(xs_r) + $signed({5'b0, dso_r, 16'b0}));
      zmag2_r  <= zmag1_r;
      zneg2_r  <= zneg1_r;
    end
  end

  // Stage 3: numerator partial products with the detector distance.
  item_t       it3_r;
  logic [56:0] nu_lo3_r;
  logic [55:0] nu_hi3_r;
  logic [62:0] nz3_r;
  logic [51:0] den3_r;
  logic        den_pos3_r, rxneg3_r, zneg3_r;

  always_ff @(posedge clk) begin
    if (en) begin
      it3_r      <= it2_r;
      nu_lo3_r   <= 57'(rxmag2_r[25:0]) * 57'(dsd_r);
      nu_hi3_r   <= 56'(rxmag2_r[50:26]) * 56'(dsd_r);
      nz3_r      <= 63'(zmag2_r) * 63'(dsd_r);
      den3_r     <= den2_r;
      den_pos3_r <= !den2_r[51] && (den2_r != '0);
      rxneg3_r   <= rxneg2_r;
      zneg3_r    <= zneg2_r;
    end
  end

  // Stage 4: divider operands.
  div_side_t          sd4_r;
  logic [DIV_NW-1:0]  nu4_r, nv4_r, nr4_r;
  logic [DIV_DW-1:0]  d4_r;

  always_ff @(posedge clk) begin
    if (en) begin
      sd4_r.item    <= it3_r;
      sd4_r.rx_neg  <= rxneg3_r;
      sd4_r.z_neg   <= zneg3_r;
      sd4_r.den_pos <= den_pos3_r;
      nu4_r         <= DIV_NW'(nu_lo3_r) + (DIV_NW'(nu_hi3_r) << 26);
      nv4_r         <= DIV_NW'(nz3_r) << 16;
      nr4_r         <= DIV_NW'(dso_r) << 48;
      d4_r          <= den_pos3_r ? den3_r : DIV_DW'(1);
    end
  end

  // Quotient pipelines for u, v and the distance ratio.
  logic [DIV_QW-1:0] uq, vq, rq;
  logic              u_ovf, v_ovf, r_ovf;

  cbvb_div #(.NW(DIV_NW), .DW(DIV_DW), .QW(DIV_QW)) u_div_u (
    .clk(clk), .en(en), .n_i(nu4_r), .d_i(d4_r), .q_o(uq), .ovf_o(u_ovf)
  );
  cbvb_div #(.NW(DIV_NW), .DW(DIV_DW), .QW(DIV_QW)) u_div_v (
    .clk(clk), .en(en), .n_i(nv4_r), .d_i(d4_r), .q_o(vq), .ovf_o(v_ovf)
  );
  cbvb_div #(.NW(DIV_NW), .DW(DIV_DW), .QW(DIV_QW)) u_div_r (
    .clk(clk), .en(en), .n_i(nr4_r), .d_i(d4_r), .q_o(rq), .ovf_o(r_ovf)
  );

  // Sideband that keeps step with the quotient pipelines.
  div_side_t sd_r [DIV_LAT];

  always_ff @(posedge clk) begin
    if (en) begin
      sd_r[0] <= sd4_r;
      for (int k = 1; k < DIV_LAT; k++) begin
        sd_r[k] <= sd_r[k-1];
      end
    end
  end

  // Stage 5: saturate quotients and offset by the first detector position.
  div_side_t          sd5_r;
  logic [48:0]        dumag5_r, dvmag5_r;
  logic               duneg5_r, dvneg5_r;
  logic [47:0]        r5_r;
  logic [DIV_QW-1:0]  u_sat, v_sat;
  logic signed [49:0] u_s, v_s, diff_u, diff_v;

  always_comb begin
    u_sat  = (u_ovf || uq > U_CAP) ? U_CAP : uq;
    v_sat  = (v_ovf || vq > U_CAP) ? U_CAP : vq;
    u_s    = sd_r[DIV_LAT-1].rx_neg ? -$signed({1'b0, u_sat}) : $signed({1'b0, u_sat});
    v_s    = sd_r[DIV_LAT-1].z_neg ? -$signed({1'b0, v_sat}) : $signed({1'b0, v_sat});
    diff_u = -u_s - 50'(ufirst_r);
    diff_v = v_s - 50'(vfirst_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd5_r    <= sd_r[DIV_LAT-1];
      dumag5_r <= diff_u[49] ? 49'(-diff_u) : 49'(diff_u);
      duneg5_r <= diff_u[49];
      dvmag5_r <= diff_v[49] ? 49'(-diff_v) : 49'(diff_v);
      dvneg5_r <= diff_v[49];
      r5_r     <= (r_ovf || rq[48]) ? {48{1'b1}} : rq[47:0];
    end
  end

  // Stage 6: position and weight partial products.
  div_side_t   sd6_r;
  logic [55:0] pu_lo6_r, pv_lo6_r;
  logic [54:0] pu_hi6_r, pv_hi6_r;
  logic [47:0] r_ll6_r, r_lh6_r, r_hh6_r;
  logic        duneg6_r, dvneg6_r;

  always_ff @(posedge clk) begin
    if (en) begin
      sd6_r    <= sd5_r;
      pu_lo6_r <= 56'(dumag5_r[24:0]) * 56'(urecip_r);
      pu_hi6_r <= 55'(dumag5_r[48:25]) * 55'(urecip_r);
      pv_lo6_r <= 56'(dvmag5_r[24:0]) * 56'(vrecip_r);
      pv_hi6_r <= 55'(dvmag5_r[48:25]) * 55'(vrecip_r);
      r_ll6_r  <= 48'(r5_r[23:0]) * 48'(r5_r[23:0]);
      r_lh6_r  <= 48'(r5_r[23:0]) * 48'(r5_r[47:24]);
      r_hh6_r  <= 48'(r5_r[47:24]) * 48'(r5_r[47:24]);
      duneg6_r <= duneg5_r;
      dvneg6_r <= dvneg5_r;
    end
  end

  // Stage 7: saturated sample positions and the squared ratio.
  div_side_t   sd7_r;
  logic [62:0] pumag7_r, pvmag7_r;
  logic        puneg7_r, pvneg7_r;
  logic [63:0] w7_r;
  logic [80:0] pos_u, pos_v;
  logic [95:0] w_full;

  always_comb begin
    pos_u  = 81'(pu_lo6_r) + (81'(pu_hi6_r) << 25);
    pos_v  = 81'(pv_lo6_r) + (81'(pv_hi6_r) << 25);
    w_full = (96'(r_hh6_r) << 48) + (96'(r_lh6_r) << 25) + 96'(r_ll6_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd7_r    <= sd6_r;
      pumag7_r <= (pos_u > POS_CAP) ? 63'(POS_CAP) : 63'(pos_u);
      pvmag7_r <= (pos_v > POS_CAP) ? 63'(POS_CAP) : 63'(pos_v);
      puneg7_r <= duneg6_r;
      pvneg7_r <= dvneg6_r;
      w7_r     <= w_full[95:32];
    end
  end

  // Stage 8: detector bounds, nearest sample and store access.
  item_t       it8_r;
  logic        hit8_r;
  logic [63:0] w8_r;
  logic [NCU_W-1:0] ncol;
  logic [NCV_W-1:0] nrow;
  logic [63:0] lim_u, lim_v, rnd_u, rnd_v;
  logic        hit_u, hit_v;
  logic [IXU_W-1:0] iu;
  logic [IXV_W-1:0] iv;
  logic [MEM_AW-1:0] raddr, waddr;
  logic        ram_we;
  logic [WORD_W-1:0] ram_rdata;

  always_comb begin
    ncol  = (int'(cols_r) > MAX_COLS) ? NCU_W'(MAX_COLS) : NCU_W'(cols_r);
    nrow  = (int'(rows_r) > MAX_ROWS) ? NCV_W'(MAX_ROWS) : NCV_W'(rows_r);
    lim_u = 64'(ncol - NCU_W'(1)) << 32;
    lim_v = 64'(nrow - NCV_W'(1)) << 32;
    hit_u = (ncol != '0) && !(puneg7_r && pumag7_r != '0) && (64'(pumag7_r) <= lim_u);
    hit_v = (nrow != '0) && !(pvneg7_r && pvmag7_r != '0) && (64'(pvmag7_r) <= lim_v);
    rnd_u = 64'(pumag7_r) + 64'h8000_0000;
    rnd_v = 64'(pvmag7_r) + 64'h8000_0000;
    iu    = IXU_W'(rnd_u[63:32]);
    iv    = IXV_W'(rnd_v[63:32]);
    raddr = MEM_AW'(iv) * MEM_AW'(MAX_COLS) + MEM_AW'(iu);
    waddr = MEM_AW'(sd7_r.item.row) * MEM_AW'(MAX_COLS) + MEM_AW'(sd7_r.item.col);
    ram_we = en && v7_r && (sd7_r.item.cmd == CMD_LOAD) &&
             (int'(sd7_r.item.col) < MAX_COLS) && (int'(sd7_r.item.row) < MAX_ROWS);
  end

  cbvb_ram #(.WIDTH(WORD_W), .DEPTH(MEM_DEPTH)) u_proj_store (
    .clk(clk), .we(ram_we), .waddr(waddr), .wdata(sd7_r.item.sample),
    .re(en), .raddr(raddr), .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      it8_r  <= sd7_r.item;
      hit8_r <= sd7_r.den_pos && hit_u && hit_v;
      w8_r   <= w7_r;
    end
  end

  // Stage 9: weight times sample magnitude, in two halves.
  item_t       it9_r;
  logic        hit9_r, sneg9_r;
  logic [63:0] plo9_r, phi9_r;
  logic [31:0] smag;

  assign smag = ram_rdata[31] ? 32'(-ram_rdata) : ram_rdata;

  always_ff @(posedge clk) begin
    if (en) begin
      it9_r   <= it8_r;
      hit9_r  <= hit8_r;
      sneg9_r <= ram_rdata[31];
      plo9_r  <= 64'(w8_r[31:0]) * 64'(smag);
      phi9_r  <= 64'(w8_r[63:32]) * 64'(smag);
    end
  end

  // Output stage: capped term, saturated sum.
  logic signed [WORD_W-1:0] out_acc_r;
  logic                     out_hit_r;
  logic [64:0]              term_full, term_cap;
  logic signed [42:0]       term_s, sum;
  logic signed [WORD_W-1:0] acc_nxt;

  always_comb begin
    term_full = 65'(phi9_r) + 65'(plo9_r[63:32]);
    term_cap  = (term_full > TERM_CAP) ? TERM_CAP : term_full;
    term_s    = sneg9_r ? -$signed(43'(term_cap)) : $signed(43'(term_cap));
    sum       = 43'(it9_r.acc) + term_s;
    if (!hit9_r) begin
      acc_nxt = it9_r.acc;
    end else if (sum > ACC_MAX) begin
      acc_nxt = 32'sh7FFF_FFFF;
    end else if (sum < ACC_MIN) begin
      acc_nxt = -32'sh8000_0000;
    end else begin
      acc_nxt = 32'(sum);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_acc_r <= acc_nxt;
      out_hit_r <= hit9_r;
    end
  end

  // Valid bits, cleared by reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0; v4_r <= 1'b0;
      v5_r <= 1'b0; v6_r <= 1'b0; v7_r <= 1'b0; v8_r <= 1'b0; v9_r <= 1'b0;
      for (int k = 0; k < DIV_LAT; k++) begin
        vd_r[k] <= 1'b0;
      end
      out_valid_r <= 1'b0;
    end else if (en) begin
      v1_r    <= in_ch.valid;
      v2_r    <= v1_r;
      v3_r    <= v2_r;
      v4_r    <= v3_r;
      vd_r[0] <= v4_r;
      for (int k = 1; k < DIV_LAT; k++) begin
        vd_r[k] <= vd_r[k-1];
      end
      v5_r <= vd_r[DIV_LAT-1];
      v6_r <= v5_r;
      v7_r <= v6_r;
      v8_r <= v7_r;
      v9_r <= v8_r;
      out_valid_r <= v9_r && (it9_r.cmd == CMD_VOXEL);
    end
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.acc_out = out_acc_r;
  assign out_ch.hit     = out_hit_r;
endmodule

// ===== hdl/cbvb_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module cbvb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;
endmodule

// ===== hdl/cbvb_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
module cbvb_div #(
  parameter int NW = 82,
  parameter int DW = 52,
  parameter int QW = 49
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] n_i,
  input  logic [DW-1:0] d_i,
  output logic [QW-1:0] q_o,
  output logic          ovf_o
);
  localparam int CW = (NW > DW + QW) ? NW : DW + QW;

  logic [CW-1:0] n_r   [QW+1];
  logic [DW-1:0] d_r   [QW+1];
  logic [QW-1:0] q_r   [QW+1];
  logic          ovf_r [QW+1];

  // Entry stage flags a quotient that does not fit; each later stage
  // settles one quotient bit from the top down.
  always_ff @(posedge clk) begin
    if (en) begin
      n_r[0]   <= CW'(n_i);
      d_r[0]   <= d_i;
      q_r[0]   <= '0;
      ovf_r[0] <= CW'(n_i) >= (CW'(d_i) << QW);
      for (int k = 0; k < QW; k++) begin
        d_r[k+1]   <= d_r[k];
        ovf_r[k+1] <= ovf_r[k];
        if (n_r[k] >= (CW'(d_r[k]) << (QW - 1 - k))) begin
          n_r[k+1] <= n_r[k] - (CW'(d_r[k]) << (QW - 1 - k));
          q_r[k+1] <= q_r[k] | (QW'(1) << (QW - 1 - k));
        end else begin
          n_r[k+1] <= n_r[k];
          q_r[k+1] <= q_r[k];
        end
      end
    end
  end

  assign q_o   = q_r[QW];
  assign ovf_o = ovf_r[QW];
endmodule

// ===== hdl/cbvb_checker.sv =====
// Port-level checker for the backprojector, bound to the top level.
module cbvb_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_acc,
  input logic        out_hit
);
`include "cone_beam_voxel_backprojector_assert.svh"

  // A held result keeps its payload.
  `CBVB_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_acc) && $stable(out_hit), "held result changed")
  // With nothing held at the output the pipeline takes input.
  `CBVB_ASSERT(a_ready_free, !out_valid |-> in_ready, "input blocked with empty output")
  // A held result stalls the whole pipeline, input included.
  `CBVB_ASSERT(a_stall_in, out_valid && !out_ready |-> !in_ready, "input taken during stall")
  // Reset empties the output register.
  `CBVB_ASSERT_RST(a_rst_empty, !rst_n |=> !out_valid, "result valid after reset")

  // The input valid is observed for completeness of the port view.
  logic unused_in_valid;
  assign unused_in_valid = in_valid;
endmodule

bind cone_beam_voxel_backprojector cbvb_checker u_cbvb_checker (
  .clk(clk),
  .rst_n(rst_n),
  .in_valid(in_ch.valid),
  .in_ready(in_ch.ready),
  .out_valid(out_ch.valid),
  .out_ready(out_ch.ready),
  .out_acc(out_ch.acc_out),
  .out_hit(out_ch.hit)
);
